// ===== sv/lzss_pkg.sv =====
// Shared types and constants of the LZSS ring-buffer decompressor.
`default_nettype none

package lzss_pkg;

    // History ring geometry.
    localparam int RING_SIZE = 4096;
    localparam int RING_AW   = $clog2(RING_SIZE);
    localparam int FILL_W    = RING_AW + 1;

    // Write pointer at the start of every stream.
    localparam logic [RING_AW-1:0] WP_INIT = RING_AW'(4078);

    // Shortest reference length.
    localparam logic [4:0] MIN_LEN = 5'd3;

    // Status codes carried on the result channel.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LIT,
        S_COPY_RD,
        S_COPY_WR,
        S_EMIT_STAT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== sv/lzss_ring_decompressor.sv =====
// LZSS ring-buffer decompressor: one compressed byte in, decompressed bytes out.
// Size, flag, first reference and dropped bytes are only taken in; a literal is written out,
// a size byte that completes a zero size emits a status, and a reference copies up to 18 bytes,
// each read and then written. A final byte that leaves the stream open reports a short header
// or a truncated stream. Each result waits in the output register while the consumer stalls.
// Synchronous active-low reset starts a new stream at once; a fill count replaces a ring clear.
`default_nettype none

module lzss_ring_decompressor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Compressed byte channel.
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_req,
    // Result channel.
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic      [7:0] o_out_byte,
    output logic            o_has_data,
    output logic            o_last,
    output logic      [1:0] o_status
);

    import lzss_pkg::*;

    // Sequencer and stream state.
    t_state               r_state, n_state;
    logic                 r_fin, n_fin;
    logic                 r_done, n_done;
    logic [2:0]           r_hdr, n_hdr;
    logic [31:0]          r_rem, n_rem;
    logic [8:0]           r_flag, n_flag;
    logic [8:0]           r_pend, n_pend;
    logic [RING_AW-1:0]   r_wp, n_wp;
    logic [FILL_W-1:0]    r_fill, n_fill;

    // Work registers of the item in hand.
    logic [RING_AW-1:0]   r_pos, n_pos;
    logic [4:0]           r_len, n_len;
    logic [7:0]           r_lit, n_lit;
    logic [1:0]           r_code, n_code;

    // Output register.
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_has;
    logic                 r_out_last;
    logic [1:0]           r_out_status;

    // Control strobes.
    logic                 accept;
    logic                 out_free;
    logic                 ring_we;
    logic                 emit_data;
    logic                 emit_stat;
    logic                 restart;

    // Ring access.
    logic [7:0]           ram_rdata;
    logic [7:0]           ring_wdata;
    logic [RING_AW-1:0]   rd_offset;
    logic                 rd_written;
    logic [7:0]           copy_byte;

    // Header accumulation.
    logic [31:0]          hdr_value;
    logic                 hdr_zero;
    logic                 dec_last;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // The ring is one memory with a write port for output bytes and a read port for copies.
    // The read address simply follows the copy position, so the data stays put while a
    // copy waits for the output register.
    lzss_ram #(
        .WIDTH (8),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (ring_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // Since a stream writes the ring contiguously from its start pointer, an entry holds
    // data of this stream exactly when its distance from that pointer lies below the fill
    // count. Any other entry reads as the zero a freshly cleared ring would hold.
    assign rd_offset  = r_pos - WP_INIT;
    assign rd_written = r_fill[RING_AW] || ({1'b0, rd_offset} < r_fill);
    assign copy_byte  = rd_written ? ram_rdata : 8'h00;

    // Place the incoming size byte into its lane of the little-endian size word.
    always_comb begin
        hdr_value = r_rem;
        unique case (r_hdr[1:0])
            2'd0: hdr_value[7:0]   = i_data_byte;
            2'd1: hdr_value[15:8]  = i_data_byte;
            2'd2: hdr_value[23:16] = i_data_byte;
            2'd3: hdr_value[31:24] = i_data_byte;
            default: hdr_value = r_rem;
        endcase
    end

    assign hdr_zero = (r_hdr == 3'd3) && (hdr_value == 32'd0);
    assign dec_last = (r_rem == 32'd1);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_final_req ? S_FINISH : S_IDLE;
                    priority if (r_done) begin
                        n_state = i_final_req ? S_FINISH : S_IDLE;
                    end else if (r_hdr < 3'd4) begin
                        if (hdr_zero) begin
                            n_state = S_EMIT_STAT;
                        end
                    end else if (r_pend[8]) begin
                        if (r_rem != 32'd0) begin
                            n_state = S_COPY_RD;
                        end
                    end else if (r_flag > 9'd1) begin
                        if (r_flag[0]) begin
                            n_state = S_LIT;
                        end
                    end
                end
            end
            S_LIT: begin
                if (out_free) begin
                    n_state = r_fin ? S_FINISH : S_IDLE;
                end
            end
            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                if (out_free) begin
                    if (dec_last || (r_len == 5'd1)) begin
                        n_state = r_fin ? S_FINISH : S_IDLE;
                    end else begin
                        n_state = S_COPY_RD;
                    end
                end
            end
            S_EMIT_STAT: begin
                if (out_free) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = r_done ? S_IDLE : S_EMIT_STAT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_ready   = (r_state == S_IDLE);
        emit_data = out_free && ((r_state == S_LIT) || (r_state == S_COPY_WR));
        emit_stat = out_free && (r_state == S_EMIT_STAT);
        ring_we   = emit_data;
        ring_wdata = (r_state == S_LIT) ? r_lit : copy_byte;
        restart   = (r_state == S_FINISH) && r_done && r_fin;
    end

    // Stream state and work registers.
    always_comb begin
        n_fin  = r_fin;
        n_done = r_done;
        n_hdr  = r_hdr;
        n_rem  = r_rem;
        n_flag = r_flag;
        n_pend = r_pend;
        n_wp   = r_wp;
        n_fill = r_fill;
        n_pos  = r_pos;
        n_len  = r_len;
        n_lit  = r_lit;
        n_code = r_code;

        if (accept) begin
            n_fin = i_final_req;
            n_lit = i_data_byte;
            priority if (r_done) begin
                // Bytes after completion are dropped.
                n_done = r_done;
            end else if (r_hdr < 3'd4) begin
                n_rem = hdr_value;
                n_hdr = r_hdr + 3'd1;
                if (hdr_zero) begin
                    n_code = ST_OK;
                end
            end else if (r_pend[8]) begin
                // Second reference byte: upper nibble extends the position, lower the length.
                n_pos  = {i_data_byte[7:4], r_pend[7:0]};
                n_len  = {1'b0, i_data_byte[3:0]} + MIN_LEN;
                n_pend = 9'd0;
            end else if (r_flag <= 9'd1) begin
                n_flag = {1'b1, i_data_byte};
            end else begin
                n_flag = {1'b0, r_flag[8:1]};
                if (!r_flag[0]) begin
                    n_pend = {1'b1, i_data_byte};
                end
            end
        end

        // Every delivered data byte also goes into the ring.
        if (emit_data) begin
            n_wp  = r_wp + RING_AW'(1);
            n_rem = r_rem - 32'd1;
            if (!r_fill[RING_AW]) begin
                n_fill = r_fill + FILL_W'(1);
            end
            if (dec_last) begin
                n_done = 1'b1;
            end
            if (r_state == S_COPY_WR) begin
                n_pos = r_pos + RING_AW'(1);
                n_len = r_len - 5'd1;
            end
        end

        if (emit_stat) begin
            n_done = 1'b1;
        end

        // A final byte that leaves the stream open reports why.
        if ((r_state == S_FINISH) && !r_done) begin
            n_code = (r_hdr < 3'd4) ? ST_SHORT : ST_TRUNC;
        end

        if (restart) begin
            n_fin  = 1'b0;
            n_done = 1'b0;
            n_hdr  = 3'd0;
            n_rem  = 32'd0;
            n_flag = 9'd0;
            n_pend = 9'd0;
            n_wp   = WP_INIT;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_done      <= 1'b0;
            r_hdr       <= 3'd0;
            r_rem       <= 32'd0;
            r_flag      <= 9'd0;
            r_pend      <= 9'd0;
            r_wp        <= WP_INIT;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= n_fin;
            r_done      <= n_done;
            r_hdr       <= n_hdr;
            r_rem       <= n_rem;
            r_flag      <= n_flag;
            r_pend      <= n_pend;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_out_valid <= emit_data || emit_stat || (r_out_valid && !i_ready);
        end
    end

    // Work and output payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_len  <= n_len;
        r_lit  <= n_lit;
        r_code <= n_code;
        if (emit_data) begin
            r_out_byte   <= ring_wdata;
            r_out_has    <= 1'b1;
            r_out_last   <= dec_last;
            r_out_status <= ST_OK;
        end else if (emit_stat) begin
            r_out_byte   <= 8'h00;
            r_out_has    <= 1'b0;
            r_out_last   <= 1'b1;
            r_out_status <= r_code;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_has_data = r_out_has;
    assign o_last     = r_out_last;
    assign o_status   = r_out_status;

endmodule

`default_nettype wire

// ===== sv/lzss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
